// ===== rtl/bfdp_pkg.sv =====
// Shared types, constants and helper functions of the bf16 x fp32 dot product unit.
package bfdp_pkg;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;
    localparam logic [31:0] POS_ZERO    = 32'h0000_0000;

    // Exponents travel as signed values wide enough for products of subnormals
    typedef logic signed [11:0] exp_t;

    // What the front learned about an item
    typedef enum logic [1:0] {
        K_FIN = 2'd0,   // finite product, possibly zero
        K_INF = 2'd1,   // infinite product
        K_INV = 2'd2,   // infinity times zero
        K_NAN = 2'd3    // NaN weight or activation, result fixed
    } kind_t;

    // Queue entry: classified item with normalized product
    typedef struct packed {
        kind_t       kind;
        logic [31:0] nan_val;
        logic        sp;       // product sign
        logic        pz;       // product is zero
        logic [47:0] pm;       // product significand, top bit at 47
        exp_t        lp;       // exponent of the product's top bit
        logic        last;
    } bfdp_entry_t;

    // Unpacked fp32 with normalized significand: value = m * 2^e
    typedef struct packed {
        logic        s;
        logic [23:0] m;
        exp_t        e;
    } unp_t;

    // Leading zero count of 24 bits (24 for zero)
    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) n = 5'(23 - i);
        end
        return n;
    endfunction

    // Leading zero count of 8 bits (8 for zero)
    function automatic logic [3:0] lzc8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd8;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) n = 4'(7 - i);
        end
        return n;
    endfunction

    // Unpack a finite fp32 and normalize its significand to bit 23
    function automatic unp_t unpack_norm(input logic [31:0] x);
        unp_t       u;
        logic [4:0] lz;
        u.s = x[31];
        if (x[30:23] == 8'd0) begin
            u.m = {1'b0, x[22:0]};
            u.e = exp_t'(-149);
        end else begin
            u.m = {1'b1, x[22:0]};
            u.e = exp_t'({4'b0, x[30:23]}) - exp_t'(150);
        end
        lz = lzc24(u.m);
        if (lz < 5'd24) begin
            u.m = u.m << lz;
            u.e = u.e - exp_t'({7'b0, lz});
        end
        return u;
    endfunction

endpackage

// ===== rtl/bfdp_front.sv =====
// Front end: accepts beats, classifies operands, forms the exact product.
module bfdp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,
    input  logic                 s_tlast,
    output logic                 push,
    input  logic                 full,
    output bfdp_pkg::bfdp_entry_t entry
);
    import bfdp_pkg::*;

    logic        s1_valid_reg;
    kind_t       s1_kind_reg;
    logic [31:0] s1_nan_reg;
    logic        s1_sp_reg;
    logic        s1_pz_reg;
    logic [23:0] s1_mw_reg;
    logic [23:0] s1_ma_reg;
    exp_t        s1_esum_reg;
    logic        s1_last_reg;

    logic [31:0] w32;
    logic [31:0] a32;
    logic        w_nan, a_nan, w_inf, a_inf, w_zero, a_zero;
    unp_t        wu, au;
    kind_t       kind_c;
    logic [31:0] nan_c;
    logic [47:0] prod;

    // Operand classification
    always_comb begin
        w32    = {s_tdata[15:0], 16'h0000};
        a32    = s_tdata[47:16];
        w_nan  = (&w32[30:23]) && (|w32[22:0]);
        a_nan  = (&a32[30:23]) && (|a32[22:0]);
        w_inf  = (&w32[30:23]) && !(|w32[22:0]);
        a_inf  = (&a32[30:23]) && !(|a32[22:0]);
        w_zero = (w32[30:0] == 31'd0);
        a_zero = (a32[30:0] == 31'd0);
        wu     = unpack_norm(w32);
        au     = unpack_norm(a32);
        nan_c  = DEFAULT_NAN;
        if (w_nan) begin
            kind_c = K_NAN;
            nan_c  = w32 | QUIET_BIT;
        end else if (a_nan) begin
            kind_c = K_NAN;
            nan_c  = a32 | QUIET_BIT;
        end else if (w_inf || a_inf) begin
            kind_c = (w_zero || a_zero) ? K_INV : K_INF;
        end else begin
            kind_c = K_FIN;
        end
    end

    assign s_tready = !s1_valid_reg || !full;
    assign push     = s1_valid_reg && !full;

    // Classification register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            s1_kind_reg <= kind_c;
            s1_nan_reg  <= nan_c;
            s1_sp_reg   <= w32[31] ^ a32[31];
            s1_pz_reg   <= w_zero || a_zero;
            s1_mw_reg   <= wu.m;
            s1_ma_reg   <= au.m;
            s1_esum_reg <= wu.e + au.e;
            s1_last_reg <= s_tlast;
        end
    end

    // Product, normalized to bit 47, written into the queue
    always_comb begin
        prod          = s1_mw_reg * s1_ma_reg;
        entry.kind    = s1_kind_reg;
        entry.nan_val = s1_nan_reg;
        entry.sp      = s1_sp_reg;
        entry.pz      = s1_pz_reg;
        entry.last    = s1_last_reg;
        if (prod[47]) begin
            entry.pm = prod;
            entry.lp = s1_esum_reg + exp_t'(47);
        end else begin
            entry.pm = {prod[46:0], 1'b0};
            entry.lp = s1_esum_reg + exp_t'(46);
        end
    end

endmodule

// ===== rtl/bfdp_queue.sv =====
// Small queue of classified items between front and back.
module bfdp_queue #(
    parameter int DEPTH = bfdp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  bfdp_pkg::bfdp_entry_t din,
    output logic                  full,
    input  logic                  pop,
    output bfdp_pkg::bfdp_entry_t dout,
    output logic                  empty
);
    import bfdp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    bfdp_entry_t   mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= din;
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/bfdp_back.sv =====
// Back end: fused add into the accumulator, normalize, round, deliver row sums.
module bfdp_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bfdp_pkg::bfdp_entry_t entry,
    input  logic                  empty,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata
);
    import bfdp_pkg::*;

    typedef enum logic [5:0] {
        S_LOAD = 6'b000001,
        S_ADD  = 6'b000010,
        S_NRM1 = 6'b000100,
        S_NRM2 = 6'b001000,
        S_RND  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] acc_reg, acc_next;
    logic        sp_reg, sp_next;
    logic [47:0] pm_reg, pm_next;
    exp_t        lp_reg, lp_next;
    logic        last_reg, last_next;
    logic        sc_reg, sc_next;
    logic [23:0] cm_reg, cm_next;
    exp_t        lc_reg, lc_next;
    logic        cz_reg, cz_next;
    logic [55:0] sum_reg, sum_next;
    logic        sgn_reg, sgn_next;
    exp_t        ex_reg, ex_next;
    exp_t        rem_reg, rem_next;
    logic [31:0] res_reg, res_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    // Load stage signals
    logic        c_nan, c_inf, c_zero;
    unp_t        cu;
    // Add stage signals
    logic        pbig, sb, ss;
    logic [47:0] bm, sm;
    exp_t        lb, d;
    logic [50:0] bw, swf, sw;
    logic [52:0] diff;
    logic [51:0] s52;
    // Normalize stage signals
    exp_t        allow, rsh;
    logic [2:0]  zb;
    logic        found;
    logic [5:0]  sh1;
    logic [3:0]  lz2, sh2;
    // Round stage signals
    logic [23:0] m24, mr;
    logic        inc;
    logic [24:0] m25;
    exp_t        er, be;
    logic        commit;

    assign pop      = (state_reg == S_LOAD) && !empty;
    assign commit   = !last_reg || !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        sp_next        = sp_reg;
        pm_next        = pm_reg;
        lp_next        = lp_reg;
        last_next      = last_reg;
        sc_next        = sc_reg;
        cm_next        = cm_reg;
        lc_next        = lc_reg;
        cz_next        = cz_reg;
        sum_next       = sum_reg;
        sgn_next       = sgn_reg;
        ex_next        = ex_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        c_nan  = (&acc_reg[30:23]) && (|acc_reg[22:0]);
        c_inf  = (&acc_reg[30:23]) && !(|acc_reg[22:0]);
        c_zero = (acc_reg[30:0] == 31'd0);
        cu     = unpack_norm(acc_reg);

        pbig = cz_reg || (lp_reg >= lc_reg);
        bm   = pbig ? pm_reg : {cm_reg, 24'h0};
        sm   = pbig ? (cz_reg ? 48'h0 : {cm_reg, 24'h0}) : pm_reg;
        sb   = pbig ? sp_reg : sc_reg;
        ss   = pbig ? sc_reg : sp_reg;
        lb   = pbig ? lp_reg : lc_reg;
        d    = pbig ? (lp_reg - lc_reg) : (lc_reg - lp_reg);
        bw   = {bm, 3'b000};
        swf  = {sm, 3'b000};
        s52  = '0;
        diff = '0;
        sw   = '0;
        allow = '0;
        rsh   = '0;
        zb    = '0;
        found = 1'b0;
        sh1   = '0;
        lz2   = '0;
        sh2   = '0;
        m24   = '0;
        mr    = '0;
        inc   = 1'b0;
        m25   = '0;
        er    = '0;
        be    = '0;

        case (state_reg)
            // Take an item, unpack the accumulator, settle special cases
            S_LOAD: begin
                if (!empty) begin
                    sp_next   = entry.sp;
                    pm_next   = entry.pm;
                    lp_next   = entry.lp;
                    last_next = entry.last;
                    sc_next   = cu.s;
                    cm_next   = cu.m;
                    lc_next   = cu.e + exp_t'(23);
                    cz_next   = c_zero;
                    state_next = S_DONE;
                    if (entry.kind == K_NAN) begin
                        res_next = entry.nan_val;
                    end else if (c_nan) begin
                        res_next = acc_reg | QUIET_BIT;
                    end else if (entry.kind == K_INV) begin
                        res_next = DEFAULT_NAN;
                    end else if (entry.kind == K_INF) begin
                        res_next = (c_inf && (acc_reg[31] != entry.sp)) ? DEFAULT_NAN
                                 : {entry.sp, 8'hFF, 23'h0};
                    end else if (c_inf) begin
                        res_next = acc_reg;
                    end else if (entry.pz) begin
                        res_next = c_zero ? {entry.sp & acc_reg[31], 31'h0} : acc_reg;
                    end else begin
                        state_next = S_ADD;
                    end
                end
            end
            // Align the smaller operand with sticky and add or subtract
            S_ADD: begin
                if (d >= exp_t'(51)) begin
                    sw = {50'h0, |sm};
                end else begin
                    sw = (swf >> d[5:0])
                       | {50'h0, |(swf & ~({51{1'b1}} << d[5:0]))};
                end
                diff = {2'b00, bw} - {2'b00, sw};
                if (sb == ss) begin
                    s52      = {1'b0, bw} + {1'b0, sw};
                    sgn_next = sb;
                end else if (!diff[52]) begin
                    s52      = diff[51:0];
                    sgn_next = sb;
                end else begin
                    s52      = {1'b0, sw} - {1'b0, bw};
                    sgn_next = ss;
                end
                sum_next   = {s52, 4'h0};
                ex_next    = lb + exp_t'(1);
                state_next = S_NRM1;
            end
            // Settle a zero sum, coarse normalize by bytes, or shift right into the subnormal range
            S_NRM1: begin
                allow = ex_reg + exp_t'(126);
                if (sum_reg == 56'h0) begin
                    res_next   = POS_ZERO;
                    state_next = S_DONE;
                end else if (allow < exp_t'(0)) begin
                    rsh = -allow;
                    if (rsh >= exp_t'(56)) begin
                        sum_next = 56'h1;
                    end else begin
                        sum_next = (sum_reg >> rsh[5:0])
                                 | {55'h0, |(sum_reg & ~({56{1'b1}} << rsh[5:0]))};
                    end
                    ex_next    = exp_t'(-126);
                    rem_next   = exp_t'(0);
                    state_next = S_NRM2;
                end else begin
                    for (int i = 6; i >= 0; i--) begin
                        if (!found) begin
                            if (sum_reg[i*8 +: 8] != 8'h0) found = 1'b1;
                            else zb = zb + 3'd1;
                        end
                    end
                    sh1 = {zb, 3'b000};
                    if (exp_t'({6'b0, sh1}) > allow) sh1 = allow[5:0];
                    sum_next   = sum_reg << sh1;
                    ex_next    = ex_reg - exp_t'({6'b0, sh1});
                    rem_next   = allow - exp_t'({6'b0, sh1});
                    state_next = S_NRM2;
                end
            end
            // Fine normalize within the top byte
            S_NRM2: begin
                lz2 = lzc8(sum_reg[55:48]);
                sh2 = (exp_t'({8'b0, lz2}) > rem_reg) ? rem_reg[3:0] : lz2;
                sum_next   = sum_reg << sh2;
                ex_next    = ex_reg - exp_t'({8'b0, sh2});
                state_next = S_RND;
            end
            // Round to nearest even and pack
            S_RND: begin
                m24 = sum_reg[55:32];
                inc = sum_reg[31] && ((|sum_reg[30:0]) || m24[0]);
                m25 = {1'b0, m24} + {24'h0, inc};
                if (m25[24]) begin
                    mr = 24'h80_0000;
                    er = ex_reg + exp_t'(1);
                end else begin
                    mr = m25[23:0];
                    er = ex_reg;
                end
                be = er + exp_t'(127);
                if (!mr[23]) begin
                    res_next = {sgn_reg, 8'h00, mr[22:0]};
                end else if (be >= exp_t'(255)) begin
                    res_next = {sgn_reg, 8'hFF, 23'h0};
                end else begin
                    res_next = {sgn_reg, be[7:0], mr[22:0]};
                end
                state_next = S_DONE;
            end
            // Update the accumulator, hand out the row sum on the last beat
            S_DONE: begin
                if (commit) begin
                    if (last_reg) begin
                        out_valid_next = 1'b1;
                        out_data_next  = res_reg;
                        acc_next       = POS_ZERO;
                    end else begin
                        acc_next = res_reg;
                    end
                    state_next = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            acc_reg       <= POS_ZERO;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        sp_reg       <= sp_next;
        pm_reg       <= pm_next;
        lp_reg       <= lp_next;
        last_reg     <= last_next;
        sc_reg       <= sc_next;
        cm_reg       <= cm_next;
        lc_reg       <= lc_next;
        cz_reg       <= cz_next;
        sum_reg      <= sum_next;
        sgn_reg      <= sgn_next;
        ex_reg       <= ex_next;
        rem_reg      <= rem_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTH
    // A delivered row sum clears the accumulator
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && commit && last_reg) |=> (acc_reg == POS_ZERO))
        else $error("accumulator not cleared after row end");

    // A taken item leaves the load state
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (state_reg == S_ADD || state_reg == S_DONE))
        else $error("item popped but back did not advance");

    // A row end waits while the output register is still held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && last_reg && out_valid_reg && !m_tready)
        |=> (state_reg == S_DONE && $stable(acc_reg)))
        else $error("row end overran a held result");
`endif

endmodule

// ===== rtl/bf16_fp32_fma_dot_product_unit.sv =====
// Top level of the bf16 weight x fp32 activation fused dot product unit.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+--------------------------------------------
//  s_      | in  | s_tvalid/s_tready | s_tdata: weight_bits, activation_bits; s_tlast
//  m_      | out | m_tvalid/m_tready | m_tdata: dot_result_bits
//
// A beat enters the front every cycle while the queue has room; the front
// registers its classification, then forms the product into the queue. The back
// steps each item through load, add, coarse and fine normalize, round and done
// around the accumulator, popping no new item before done (a zero sum skips fine
// normalize and round; NaN, infinity and zero-product cases go from load to done);
// this sets the sustained rate. Reset (aresetn low, synchronous) empties the queue
// and sets the accumulator to +0.0. A stalled m_ side holds only row-end beats.
module bf16_fp32_fma_dot_product_unit #(
    parameter int QUEUE_DEPTH = bfdp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] weight_bits, [47:16] activation_bits
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] dot_result_bits
);
    import bfdp_pkg::*;

    bfdp_entry_t q_in, q_out;
    logic        q_push, q_pop, q_full, q_empty;

    bfdp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .push     (q_push),
        .full     (q_full),
        .entry    (q_in)
    );

    bfdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_out),
        .empty   (q_empty)
    );

    bfdp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .entry    (q_out),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the bf16 x fp32 fused multiply-add dot product unit.
`timescale 1ns / 100ps

module testbench;
    import bfdp_pkg::*;

    localparam int IDLE_LIMIT = 3000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // [15:0] weight_bits, [47:16] activation_bits
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] dot_result_bits

    logic [31:0] row_sums_pending[$];
    logic [31:0] acc_model;
    int          mismatches;
    int          idle_cycles;
    int          long_hold;
    bit          quiet_tail;

    bf16_fp32_fma_dot_product_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ---------------- fp32 arithmetic model ----------------

    function automatic int msb_index(input longint unsigned v);
        int n;
        n = 0;
        while (v > 64'd1) begin
            v = v >> 1;
            n++;
        end
        return n;
    endfunction

    // value = m * 2^e for a finite fp32
    function automatic void split_fp32(input logic [31:0] x, output logic s,
                                       output longint unsigned m, output int e);
        s = x[31];
        if (x[30:23] == 8'd0) begin
            m = {41'd0, x[22:0]};
            e = -149;
        end else begin
            m = {40'd0, 1'b1, x[22:0]};
            e = int'(x[30:23]) - 150;
        end
    endfunction

    // round sign * v * 2^eb (v nonzero) to fp32, nearest-even
    function automatic logic [31:0] round_fp32(input logic sign, input longint unsigned v,
                                               input int eb);
        int              sh;
        int              q;
        int              be;
        longint unsigned m;
        longint unsigned rem;
        longint unsigned half;
        sh = msb_index(v) - 23;
        if (-149 - eb > sh) sh = -149 - eb;
        if (sh <= 0) begin
            m = v << (-sh);
        end else if (sh >= 65) begin
            m = 0;
        end else begin
            half = 64'd1 << (sh - 1);
            if (sh == 64) begin
                m = 0;
                rem = v;
            end else begin
                m = v >> sh;
                rem = v & ((64'd1 << sh) - 64'd1);
            end
            if (rem > half || (rem == half && m[0])) m++;
        end
        q = eb + sh;
        if (m >= 64'h0100_0000) begin
            m = m >> 1;
            q++;
        end
        if (m < 64'h0080_0000) return {sign, m[30:0]};
        be = q + 150;
        if (be >= 255) return {sign, 8'hFF, 23'd0};
        return {sign, be[7:0], m[22:0]};
    endfunction

    function automatic bit fp_nan(input logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 23'd0;
    endfunction

    function automatic bit fp_inf(input logic [31:0] x);
        return x[30:0] == 31'h7F80_0000;
    endfunction

    function automatic bit fp_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    // acc + w * a with one rounding
    function automatic logic [31:0] fused_mac(input logic [31:0] w, input logic [31:0] a,
                                              input logic [31:0] c);
        logic            sw, sa, sc, sp, sb, ss, sgn;
        longint unsigned mw, ma, mc, mp, mb, ms, total, lost;
        int              ew, ea, ec, ep, lp, lc, lb, d;
        if (fp_nan(w)) return w | QUIET_BIT;
        if (fp_nan(a)) return a | QUIET_BIT;
        if (fp_nan(c)) return c | QUIET_BIT;
        if (fp_inf(w) || fp_inf(a)) begin
            if (fp_zero(w) || fp_zero(a)) return DEFAULT_NAN;
            sp = w[31] ^ a[31];
            if (fp_inf(c) && c[31] != sp) return DEFAULT_NAN;
            return {sp, 8'hFF, 23'd0};
        end
        if (fp_inf(c)) return c;
        split_fp32(w, sw, mw, ew);
        split_fp32(a, sa, ma, ea);
        split_fp32(c, sc, mc, ec);
        mp = mw * ma;
        ep = ew + ea;
        sp = sw ^ sa;
        if (mp == 0) begin
            if (mc == 0) return {sp & sc, 31'd0};
            return c;
        end
        if (mc == 0) return round_fp32(sp, mp, ep);
        lp = ep + msb_index(mp);
        lc = ec + msb_index(mc);
        mp = mp << (62 - msb_index(mp));
        mc = mc << (62 - msb_index(mc));
        if (lp >= lc) begin
            mb = mp; sb = sp; lb = lp; ms = mc; ss = sc; d = lp - lc;
        end else begin
            mb = mc; sb = sc; lb = lc; ms = mp; ss = sp; d = lc - lp;
        end
        // align the smaller term, folding shifted-out bits into a sticky bit
        if (d >= 64) begin
            ms = 1;
        end else if (d > 0) begin
            lost = ms & ((64'd1 << d) - 64'd1);
            ms = ms >> d;
            if (lost != 0) ms = ms | 64'd1;
        end
        if (sb == ss) begin
            total = mb + ms;
            sgn = sb;
        end else if (mb >= ms) begin
            total = mb - ms;
            sgn = sb;
        end else begin
            total = ms - mb;
            sgn = ss;
        end
        if (total == 0) return POS_ZERO;
        return round_fp32(sgn, total, lb - 62);
    endfunction

    // ---------------- input side ----------------

    // drive one beat, wait for its handshake, then maybe idle
    task automatic send_column(input logic [15:0] w, input logic [31:0] a, input logic last);
        logic [31:0] nxt;
        int          gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {a, w};
        s_tlast  <= last;
        forever begin
            @(negedge aclk);
            if (s_tready) begin
                @(posedge aclk);
                break;
            end
            @(posedge aclk);
        end
        nxt = fused_mac({w, 16'd0}, a, acc_model);
        if (last) begin
            row_sums_pending.push_back(nxt);
            acc_model = POS_ZERO;
        end else begin
            acc_model = nxt;
        end
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // ---------------- output side ----------------

    // receiver stalls: long hold on request, short random bursts otherwise
    initial begin
        int stall;
        stall = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold > 0) begin
                m_tready <= 1'b0;
                long_hold--;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // check each result beat; sampled mid-cycle, taken at the next rising edge
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (row_sums_pending.size() == 0) begin
                $error("unexpected beat: dot_result_bits actual %h", m_tdata);
                mismatches++;
            end else begin
                logic [31:0] want;
                want = row_sums_pending.pop_front();
                if (m_tdata !== want) begin
                    $error("dot_result_bits expected %h actual %h", want, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(negedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic logic [15:0] pick_weight();
        logic [15:0] w;
        case ($urandom_range(0, 9))
            0: w = 16'($urandom);
            1: w = {1'($urandom), 8'($urandom_range(0, 1)) * 8'hFF, 7'($urandom)};
            2: w = {1'($urandom), 8'd0, 7'($urandom)};
            default: w = {1'($urandom), 8'($urandom_range(110, 140)), 7'($urandom)};
        endcase
        return w;
    endfunction

    function automatic logic [31:0] pick_activation();
        logic [31:0] a;
        case ($urandom_range(0, 9))
            0: a = $urandom;
            1: a = {1'($urandom), 8'($urandom_range(0, 1)) * 8'hFF, 23'($urandom)};
            2: a = {1'($urandom), 8'd0, 23'($urandom)};
            3: a = {1'($urandom), 8'($urandom_range(0, 30)), 23'($urandom)};
            4: a = {1'($urandom), 8'($urandom_range(225, 254)), 23'($urandom)};
            default: a = {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
        endcase
        return a;
    endfunction

    task automatic send_random_rows(input int columns, input int max_row);
        int left;
        int len;
        left = columns;
        while (left > 0) begin
            len = $urandom_range(1, max_row);
            if (len > left) len = left;
            for (int i = 0; i < len; i++)
                send_column(pick_weight(), pick_activation(), i == len - 1);
            left -= len;
        end
    endtask

    task automatic test_special_cases();
        send_column(16'h7F81, 32'h3F80_0000, 1'b1);   // signaling NaN weight
        send_column(16'h3F80, 32'hFF80_0001, 1'b1);   // NaN activation
        send_column(16'hFFC1, 32'h7FBF_FFFF, 1'b1);   // two NaNs, weight wins
        send_column(16'h7F80, 32'h0000_0000, 1'b1);   // infinity times zero
        send_column(16'h7F80, 32'h3F80_0000, 1'b0);   // inf then -inf
        send_column(16'hFF80, 32'h3F80_0000, 1'b1);
        send_column(16'h7F80, 32'h4000_0000, 1'b0);   // inf accumulator kept
        send_column(16'h3F80, 32'h3F80_0000, 1'b1);
        send_column(16'h7FC0, 32'h3F80_0000, 1'b0);   // NaN accumulator carried
        send_column(16'h3F80, 32'h3F80_0000, 1'b1);
        send_column(16'h8000, 32'h0000_0000, 1'b1);   // signed zeros
        send_column(16'h8000, 32'h8000_0000, 1'b1);
        send_column(16'h3F80, 32'h4040_0000, 1'b0);   // exact cancellation
        send_column(16'hBF80, 32'h4040_0000, 1'b1);
        send_column(16'h7F7F, 32'h7F7F_FFFF, 1'b1);   // overflow
        send_column(16'hFF7F, 32'h7F7F_FFFF, 1'b1);
        send_column(16'h0080, 32'h0000_0001, 1'b1);   // underflow to zero
        send_column(16'h3F00, 32'h0000_0001, 1'b1);   // tie to even subnormal
        send_column(16'h3FC0, 32'h8000_0001, 1'b1);
        send_column(16'hFFFF, 32'hFFFF_FFFF, 1'b1);   // all ones
        send_column(16'h0000, 32'h0000_0000, 1'b1);   // all zeros
        send_column(16'h0001, 32'h007F_FFFF, 1'b0);   // subnormal products
        send_column(16'h3F80, 32'h0080_0000, 1'b1);
    endtask

    task automatic test_random_rows();
        send_random_rows(440, 8);
    endtask

    // hold the receiver off while many short rows pile up
    task automatic test_output_backpressure();
        long_hold = 250;
        for (int i = 0; i < 30; i++)
            send_column(pick_weight(), pick_activation(), 1'b1);
    endtask

    task automatic test_full_rate();
        quiet_tail = 1'b1;
        send_random_rows(60, 4);
    endtask

    initial begin
        mismatches  = 0;
        idle_cycles = 0;
        long_hold   = 0;
        quiet_tail  = 1'b0;
        acc_model   = POS_ZERO;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_special_cases();
        test_random_rows();
        test_output_backpressure();
        test_full_rate();
        s_tvalid <= 1'b0;

        // drain, then allow the back end to settle
        while (row_sums_pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bfdp_pkg.sv
rtl/bfdp_front.sv
rtl/bfdp_queue.sv
rtl/bfdp_back.sv
rtl/bf16_fp32_fma_dot_product_unit.sv
sim/testbench.sv
